/* hw/rtl/ovn_pkg.sv */
// Shared types, constants and the cosine blend table for the octave value noise block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package ovn_pkg;

	// Block dimensions
	localparam int MAX_OCTAVES     = 8;
	localparam int COORD_FRAC_BITS = 16;
	localparam int COS_TABLE_BITS  = 8;

	// Coordinate width after scaling by up to 2^(MAX_OCTAVES-1)
	localparam int CW          = 32 + MAX_OCTAVES - 1;
	localparam int TAB_SIZE    = (1 << COS_TABLE_BITS) + 1;
	localparam int TAB_IDX_W   = COS_TABLE_BITS + 1;
	localparam int WREM_W      = COORD_FRAC_BITS - COS_TABLE_BITS;
	localparam int CELL_STAGES = 13;
	localparam int CNT_W       = 4;
	localparam int PER_W       = 16;
	localparam int AMP_W       = 31;

	// Fixed-point constants
	localparam logic [PER_W-1:0]  PERSIST_MAX = 16'd32768;
	localparam logic [PER_W-1:0]  PERSIST_RST = 16'd16384;
	localparam logic [CNT_W-1:0]  COUNT_RST   = 4'd4;
	localparam logic [AMP_W-1:0]  AMP_ONE     = 31'h4000_0000;
	localparam logic signed [31:0] ONE_Q30    = 32'sh4000_0000;
	localparam longint unsigned   PI_HALF_Q30 = 64'd1686629713;

	// Lattice hash constants
	localparam logic [31:0] HASH_Y_MUL = 32'd57;
	localparam int          HASH_SHIFT = 13;
	localparam logic [31:0] HASH_MUL_B = 32'd15731;
	localparam logic [31:0] HASH_ADD_B = 32'd789221;
	localparam logic [31:0] HASH_ADD_C = 32'd1376312589;

	// Configuration register indexes
	localparam logic [7:0] REG_PERSISTENCE  = 8'd0;
	localparam logic [7:0] REG_OCTAVE_COUNT = 8'd1;

	// Taylor series divisors (2n)(2n+1) for the sine terms
	localparam longint unsigned TAYLOR_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// Link between neighboring octave cells
	typedef struct packed {
		logic                    valid;
		logic signed [CW-1:0]    cx;
		logic signed [CW-1:0]    cy;
		logic signed [31:0]      sum;
		logic [AMP_W-1:0]        amp;
	} link_t;

	typedef logic [30:0] wave_tab_t [TAB_SIZE];

	// Build the sin^2 quarter-wave table in Q.30 at elaboration
	function automatic wave_tab_t build_wave_tab();
		wave_tab_t tab;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint s;
		for (int k = 0; k < TAB_SIZE; k++) begin
			x    = (PI_HALF_Q30 * longint'(k)) >> COS_TABLE_BITS;
			x2   = (x * x) >> 30;
			term = x;
			s    = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
				if (n % 2 == 1) begin
					s = s - longint'(term);
				end else begin
					s = s + longint'(term);
				end
			end
			if (s < 0) s = 0;
			if (s > 64'sd1073741824) s = 64'sd1073741824;
			s = longint'((longint'(unsigned'(s)) * s) >>> 30);
			if (s > 64'sd1073741824) s = 64'sd1073741824;
			tab[k] = 31'(s);
		end
		return tab;
	endfunction

	localparam wave_tab_t WAVE_TAB = build_wave_tab();

endpackage

/* hw/rtl/ovn_hash.sv */
// One lattice point hash pipeline: integer hash of (x, y) turned into a Q1.30 value.
// Depends on ovn_pkg for the hash constants.
`timescale 1ns / 1ps

module ovn_hash (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        x,
	input  logic [31:0]        y,
	output logic signed [31:0] lat
);

	logic [31:0] n0;
	logic [31:0] n_s2;
	logic [31:0] sq_s3;
	logic [31:0] n_s3;
	logic [31:0] t_s4;
	logic [31:0] n_s4;
	logic [31:0] u_s5;
	logic signed [31:0] lat_s6;

	// Mix the coordinates into one word
	assign n0 = x + y * ovn_pkg::HASH_Y_MUL;

	// Advance the hash polynomial, with at most one multiply in any stage
	always_ff @(posedge clk) begin
		if (en) begin
			n_s2   <= (n0 << ovn_pkg::HASH_SHIFT) ^ n0;
			sq_s3  <= n_s2 * n_s2;
			n_s3   <= n_s2;
			t_s4   <= sq_s3 * ovn_pkg::HASH_MUL_B + ovn_pkg::HASH_ADD_B;
			n_s4   <= n_s3;
			u_s5   <= n_s4 * t_s4 + ovn_pkg::HASH_ADD_C;
			lat_s6 <= ovn_pkg::ONE_Q30 - $signed({1'b0, u_s5[30:0]});
		end
	end

	assign lat = lat_s6;

endmodule

/* hw/rtl/ovn_cell.sv */
// One octave cell: split, 4x4 lattice hash, smoothing, cosine blend, weighted accumulate.
// Depends on ovn_pkg and ovn_hash.
`timescale 1ns / 1ps

module ovn_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic [ovn_pkg::CNT_W-1:0]       idx,
	input  logic [ovn_pkg::CNT_W-1:0]       count,
	input  logic [ovn_pkg::PER_W-1:0]       persist,
	input  ovn_pkg::link_t                  up,
	output ovn_pkg::link_t                  down
);

	localparam int NS  = ovn_pkg::CELL_STAGES;
	localparam int CW  = ovn_pkg::CW;
	localparam int CFB = ovn_pkg::COORD_FRAC_BITS;
	localparam int CTB = ovn_pkg::COS_TABLE_BITS;
	localparam int WR  = ovn_pkg::WREM_W;
	localparam int AW  = ovn_pkg::AMP_W;

	logic [NS-1:0]          valid_q;
	logic signed [CW-1:0]   cx_q   [NS];
	logic signed [CW-1:0]   cy_q   [NS];
	logic [AW-1:0]          ampn_q [NS];
	logic [AW-1:0]          amp_q  [NS-2];
	logic signed [31:0]     sum_q  [NS-1];

	// Split results
	logic                   neg [2];
	logic [CW-1:0]          mag [2];
	logic [CW-1:0]          ipart [2];
	logic [31:0]            ip_c [2];
	logic [31:0]            ix_s1, iy_s1;
	logic [CFB-1:0]         fr_s1 [2];
	logic [AW+ovn_pkg::PER_W-1:0] amp_prod;

	// Weight path
	logic [ovn_pkg::TAB_IDX_W-1:0] k_lo [2];
	logic [ovn_pkg::TAB_IDX_W-1:0] k_hi [2];
	logic [30:0]            wlo_s2 [2];
	logic [30:0]            wdiff_s2 [2];
	logic [WR-1:0]          wrem_s2 [2];
	logic [30:0]            wlo_s3 [2];
	logic [30+WR:0]         wprod_s3 [2];
	logic [30:0]            w_s4 [2];
	logic [30:0]            w_s5 [2];
	logic [30:0]            w_s6 [2];
	logic [30:0]            w_s7 [2];
	logic [30:0]            wy_s8;
	logic [30:0]            wy_s9;

	// Lattice and blend path
	logic signed [31:0]     lat_s6 [4][4];
	logic signed [35:0]     acc [4];
	logic signed [31:0]     v_s7 [4];
	logic signed [32:0]     bd [2];
	logic signed [63:0]     bxp_s8 [2];
	logic signed [31:0]     a_s8 [2];
	logic signed [31:0]     h_s9 [2];
	logic signed [32:0]     byd;
	logic signed [63:0]     byp_s10;
	logic signed [31:0]     h1_s10;
	logic signed [31:0]     val_s11;
	logic signed [63:0]     tp_s12;
	logic signed [31:0]     sum_s13;
	logic                   active;

	// Truncate toward zero and keep the fraction magnitude
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			neg[c]   = (c == 0) ? up.cx[CW-1] : up.cy[CW-1];
			mag[c]   = (c == 0) ? (neg[c] ? CW'(-up.cx) : CW'(up.cx))
			                    : (neg[c] ? CW'(-up.cy) : CW'(up.cy));
			ipart[c] = mag[c] >> CFB;
			ip_c[c]  = neg[c] ? 32'd0 - ipart[c][31:0] : ipart[c][31:0];
		end
	end

	assign amp_prod = up.amp * persist;

	// Stage 1: split and next amplitude
	always_ff @(posedge clk) begin
		if (en) begin
			ix_s1     <= ip_c[0];
			iy_s1     <= ip_c[1];
			fr_s1[0]  <= mag[0][CFB-1:0];
			fr_s1[1]  <= mag[1][CFB-1:0];
			ampn_q[0] <= amp_prod[AW+14:15];
			amp_q[0]  <= up.amp;
			cx_q[0]   <= up.cx;
			cy_q[0]   <= up.cy;
			sum_q[0]  <= up.sum;
		end
	end

	// Carry the item fields along the cell
	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 1; s < NS; s++) begin
				cx_q[s]   <= cx_q[s-1];
				cy_q[s]   <= cy_q[s-1];
				ampn_q[s] <= ampn_q[s-1];
			end
			for (int s = 1; s < NS - 2; s++) begin
				amp_q[s] <= amp_q[s-1];
			end
			for (int s = 1; s < NS - 1; s++) begin
				sum_q[s] <= sum_q[s-1];
			end
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[NS-2:0], up.valid};
		end
	end

	// Table addresses for the interpolated weight
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			k_lo[c] = {1'b0, fr_s1[c][CFB-1 -: CTB]};
			k_hi[c] = k_lo[c] + 1'b1;
		end
	end

	// Stages 2 to 4: look up, scale the step, add; later stages only delay the weights
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 2; c++) begin
				wlo_s2[c]   <= ovn_pkg::WAVE_TAB[k_lo[c]];
				wdiff_s2[c] <= ovn_pkg::WAVE_TAB[k_hi[c]] - ovn_pkg::WAVE_TAB[k_lo[c]];
				wrem_s2[c]  <= fr_s1[c][WR-1:0];
				wlo_s3[c]   <= wlo_s2[c];
				wprod_s3[c] <= wdiff_s2[c] * wrem_s2[c];
				w_s4[c]     <= wlo_s3[c] + 31'(wprod_s3[c] >> WR);
				w_s5[c]     <= w_s4[c];
				w_s6[c]     <= w_s5[c];
				w_s7[c]     <= w_s6[c];
			end
			wy_s8 <= w_s7[1];
			wy_s9 <= wy_s8;
		end
	end

	// Hash the 4x4 neighborhood, rows iy-1..iy+2, columns ix-1..ix+2
	for (genvar gy = 0; gy < 4; gy++) begin : g_row
		for (genvar gx = 0; gx < 4; gx++) begin : g_col
			ovn_hash u_hash (
				.clk (clk),
				.en  (en),
				.x   (ix_s1 + 32'(gx) - 32'd1),
				.y   (iy_s1 + 32'(gy) - 32'd1),
				.lat (lat_s6[gy][gx])
			);
		end
	end

	// Weighted 3x3 sums for the four cells around the sample
	always_comb begin
		for (int b = 0; b < 2; b++) begin
			for (int a = 0; a < 2; a++) begin
				acc[b*2+a] = 36'(lat_s6[b][a]) + 36'(lat_s6[b][a+2])
				           + 36'(lat_s6[b+2][a]) + 36'(lat_s6[b+2][a+2])
				           + ((36'(lat_s6[b+1][a]) + 36'(lat_s6[b+1][a+2])
				             + 36'(lat_s6[b][a+1]) + 36'(lat_s6[b+2][a+1])) <<< 1)
				           + (36'(lat_s6[b+1][a+1]) <<< 2);
			end
		end
	end

	assign bd[0] = 33'(v_s7[1]) - 33'(v_s7[0]);
	assign bd[1] = 33'(v_s7[3]) - 33'(v_s7[2]);
	assign byd   = 33'(h_s9[1]) - 33'(h_s9[0]);
	assign active = idx < count;

	// Stages 7 to 13: smooth, blend along x then y, weight and accumulate
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				v_s7[i] <= 32'(acc[i] >>> 4);
			end
			for (int i = 0; i < 2; i++) begin
				bxp_s8[i] <= bd[i] * $signed({1'b0, w_s7[0]});
				a_s8[i]   <= v_s7[i*2];
				h_s9[i]   <= 32'(a_s8[i] + (bxp_s8[i] >>> 30));
			end
			byp_s10 <= byd * $signed({1'b0, wy_s9});
			h1_s10  <= h_s9[0];
			val_s11 <= 32'(h1_s10 + (byp_s10 >>> 30));
			tp_s12  <= val_s11 * $signed({1'b0, amp_q[NS-3]});
			sum_s13 <= sum_q[NS-2] + (active ? 32'(tp_s12 >>> 36) : 32'sd0);
		end
	end

	// Hand the item to the next octave at twice the scale
	assign down.valid = valid_q[NS-1];
	assign down.cx    = cx_q[NS-1] <<< 1;
	assign down.cy    = cy_q[NS-1] <<< 1;
	assign down.sum   = sum_s13;
	assign down.amp   = ampn_q[NS-1];

endmodule

/* hw/rtl/octave_value_noise_2d.sv */
// Top level of the multi-octave 2D value noise block: config registers, octave chain, output.
// Depends on ovn_pkg and ovn_cell.
//
// Usage:
//   Coordinates enter on the coord channel (coord_x, coord_y, signed Q16.16) with
//   coord_valid/coord_ready; one noise_value (signed Q8.24) leaves on the noise
//   channel per coordinate, in order.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 persistence, 1 octave_count)
//   and cfg_data; cfg_ready is always high. Write only while no item is in flight.
//   Throughput: one coordinate per cycle while the chain is not stalled. Each octave is a
//   13-stage cell and the chain has 8 of them plus an output register.
//   Stall: when noise_ready is low and the output register is full, the chain keeps
//   moving as long as its last stage is empty; once that stage holds an item the
//   whole chain holds and coord_ready drops.
//   Reset: persistence returns to 0.5, octave_count to 4 and the chain empties.
`timescale 1ns / 1ps

module octave_value_noise_2d (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               coord_valid,
	output logic               coord_ready,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	output logic               noise_valid,
	input  logic               noise_ready,
	output logic signed [31:0] noise_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int NO = ovn_pkg::MAX_OCTAVES;

	logic [ovn_pkg::PER_W-1:0] persistence_q;
	logic [ovn_pkg::CNT_W-1:0] octave_count_q;
	logic [ovn_pkg::PER_W-1:0] persist_eff;
	ovn_pkg::link_t            link [NO+1];
	logic                      en;
	logic                      out_valid_q;
	logic signed [31:0]        out_value_q;

	// Register writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			persistence_q  <= ovn_pkg::PERSIST_RST;
			octave_count_q <= ovn_pkg::COUNT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ovn_pkg::REG_PERSISTENCE:  persistence_q  <= cfg_data;
				ovn_pkg::REG_OCTAVE_COUNT: octave_count_q <= cfg_data[ovn_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign persist_eff = (persistence_q > ovn_pkg::PERSIST_MAX) ? ovn_pkg::PERSIST_MAX
	                                                           : persistence_q;

	// Advance the chain unless the last stage would overrun a stalled output
	assign en          = !out_valid_q || noise_ready || !link[NO].valid;
	assign coord_ready = en;

	assign link[0].valid = coord_valid;
	assign link[0].cx    = ovn_pkg::CW'(coord_x);
	assign link[0].cy    = ovn_pkg::CW'(coord_y);
	assign link[0].sum   = 32'sd0;
	assign link[0].amp   = ovn_pkg::AMP_ONE;

	// One cell per octave
	for (genvar g = 0; g < NO; g++) begin : g_oct
		ovn_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.idx     (ovn_pkg::CNT_W'(g)),
			.count   (octave_count_q),
			.persist (persist_eff),
			.up      (link[g]),
			.down    (link[g+1])
		);
	end

	// Output register; the sum stays well inside 32 bits so no clamp is needed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (link[NO].valid && en) begin
			out_valid_q <= 1'b1;
		end else if (noise_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (link[NO].valid && en) begin
			out_value_q <= link[NO].sum;
		end
	end

	assign noise_valid = out_valid_q;
	assign noise_value = out_value_q;

	// Input side only blocks while a finished result is stuck
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!coord_ready |-> (noise_valid && !noise_ready))
		else $error("coord_ready low without a stalled output");

	// An item leaving the chain lands in the output register
	a_chain_out: assert property (@(posedge clk) disable iff (!arst_n)
		(link[NO].valid && en) |=> noise_valid)
		else $error("chain output lost");

	// Octave count write takes effect
	a_count_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == ovn_pkg::REG_OCTAVE_COUNT)
		|=> octave_count_q == $past(cfg_data[ovn_pkg::CNT_W-1:0]))
		else $error("octave_count write not applied");

endmodule
